// ----- rtl/mt64_pkg.sv -----
// Shared types, constants and word functions of the 64-bit Mersenne Twister generator.
package mt64_pkg;

    localparam int STATE_WORDS   = 312;
    localparam int MIDDLE_OFFSET = 156;
    localparam int IDX_W         = 9;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [63:0]      word_t;

    localparam idx_t IDX_LAST = idx_t'(STATE_WORDS - 1);
    localparam idx_t IDX_MID  = idx_t'(MIDDLE_OFFSET);

    localparam word_t SEED_MULT  = 64'd6364136223846793005;
    localparam int    SEED_SHIFT = 62;
    localparam word_t TWIST_XOR  = 64'hb5026f5aa96619e9;
    localparam word_t LOW_BITS   = 64'h000000007fffffff;
    localparam word_t HIGH_BITS  = ~LOW_BITS;
    localparam int    TEMPER_S1  = 29;
    localparam word_t TEMPER_M1  = 64'h5555555555555555;
    localparam int    TEMPER_S2  = 17;
    localparam word_t TEMPER_M2  = 64'h71d67fffeda60000;
    localparam int    TEMPER_S3  = 37;
    localparam word_t TEMPER_M3  = 64'hfff7eee000000000;
    localparam int    TEMPER_S4  = 43;

    typedef enum logic [3:0] {
        ST_SEED_INIT,
        ST_SEED_MUL0,
        ST_SEED_MUL1,
        ST_SEED_MUL2,
        ST_SEED_WRITE,
        ST_IDLE,
        ST_READ,
        ST_READ_MID,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic seed_init;
        logic mul0;
        logic mul1;
        logic mul2;
        logic seed_wr;
        logic rd_pair;
        logic rd_mid;
        logic draw_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic seed_last;
        logic out_free;
    } dp_status_t;

    function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t mid);
        word_t mix;
        word_t shifted;
        mix     = (cur & HIGH_BITS) | (nxt & LOW_BITS);
        shifted = (mix >> 1) ^ (mix[0] ? TWIST_XOR : 64'd0);
        return mid ^ shifted;
    endfunction

    function automatic word_t temper_word(input word_t y_in);
        word_t y;
        y = y_in;
        y = y ^ ((y >> TEMPER_S1) & TEMPER_M1);
        y = y ^ ((y << TEMPER_S2) & TEMPER_M2);
        y = y ^ ((y << TEMPER_S3) & TEMPER_M3);
        y = y ^ (y >> TEMPER_S4);
        return y;
    endfunction

endpackage

// ----- rtl/mt64_ctrl.sv -----
// Controller state machine that sequences seeding and draws of the generator.
module mt64_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                advance,
    input  logic                cfg_write,
    input  mt64_pkg::dp_status_t status,
    output mt64_pkg::dp_cmd_t    cmd,
    output logic                in_stall
);
    import mt64_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SEED_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_SEED_INIT:
            begin
                cmd.seed_init = 1'b1;
                state_next    = ST_SEED_MUL0;
            end
            ST_SEED_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = ST_SEED_MUL1;
            end
            ST_SEED_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_SEED_MUL2;
            end
            ST_SEED_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_SEED_WRITE;
            end
            ST_SEED_WRITE:
            begin
                cmd.seed_wr = 1'b1;
                state_next  = status.seed_last ? ST_IDLE : ST_SEED_MUL0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && advance)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_pair = 1'b1;
                state_next  = ST_READ_MID;
            end
            ST_READ_MID:
            begin
                cmd.rd_mid = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.draw_wr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SEED_INIT;
            end
        endcase
        if (cfg_write)
        begin
            state_next = ST_SEED_INIT;
        end
    end

    a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && advance && !cfg_write) |=> state_reg == ST_READ)
        else $error("accepted draw request did not start a read");

    a_seed_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED_WRITE && status.seed_last && !cfg_write) |=> state_reg == ST_IDLE)
        else $error("seeding pass did not end after the last word");

    a_cfg_reseeds: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> state_reg == ST_SEED_INIT)
        else $error("seed write did not restart seeding");

endmodule

// ----- rtl/mt64_datapath.sv -----
// Datapath of the generator: state memory, seeding multiplier, twist, tempering and output word.
module mt64_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [63:0]          seed_value,
    input  mt64_pkg::dp_cmd_t     cmd,
    output mt64_pkg::dp_status_t  status,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [63:0]          random_word
);
    import mt64_pkg::*;

    word_t mem [STATE_WORDS];

    word_t seed_reg;
    word_t x_reg;
    word_t prod_reg;
    word_t acc_reg;
    word_t rd_a_reg;
    word_t rd_b_reg;
    word_t cur_reg;
    word_t word_reg;
    idx_t  idx_reg;
    logic  out_valid_reg;

    word_t       t_word;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    word_t       prod_next;
    word_t       seed_word;
    word_t       draw_word;
    idx_t        idx_inc;
    idx_t        nxt_idx;
    idx_t        mid_idx;
    logic        mem_we;
    idx_t        wr_addr;
    word_t       wr_data;

    assign t_word    = x_reg ^ (x_reg >> SEED_SHIFT);
    assign idx_inc   = (idx_reg == IDX_LAST) ? '0 : idx_reg + idx_t'(1);
    assign nxt_idx   = idx_inc;
    assign mid_idx   = (idx_reg < IDX_MID) ? idx_reg + IDX_MID : idx_reg - IDX_MID;
    assign seed_word = acc_reg + {prod_reg[31:0], 32'd0};
    assign draw_word = twist_word(cur_reg, rd_b_reg, rd_a_reg);

    always_comb
    begin
        mul_a = t_word[31:0];
        mul_b = SEED_MULT[31:0];
        if (cmd.mul1)
        begin
            mul_b = SEED_MULT[63:32];
        end
        else if (cmd.mul2)
        begin
            mul_a = t_word[63:32];
        end
    end

    assign prod_next = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        mem_we  = cmd.seed_init | cmd.seed_wr | cmd.draw_wr;
        wr_addr = idx_reg;
        wr_data = draw_word;
        if (cmd.seed_init)
        begin
            wr_addr = '0;
            wr_data = seed_reg;
        end
        else if (cmd.seed_wr)
        begin
            wr_data = seed_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_pair)
        begin
            rd_a_reg <= mem[idx_reg];
            rd_b_reg <= mem[nxt_idx];
        end
        else if (cmd.rd_mid)
        begin
            rd_a_reg <= mem[mid_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_init)
        begin
            x_reg   <= seed_reg;
            idx_reg <= idx_t'(1);
        end
        if (cmd.mul0 || cmd.mul1 || cmd.mul2)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul1)
        begin
            acc_reg <= prod_reg + 64'(idx_reg);
        end
        if (cmd.mul2)
        begin
            acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
        end
        if (cmd.seed_wr)
        begin
            x_reg   <= seed_word;
            idx_reg <= idx_inc;
        end
        if (cmd.rd_mid)
        begin
            cur_reg <= rd_a_reg;
        end
        if (cmd.draw_wr)
        begin
            word_reg <= temper_word(draw_word);
            idx_reg  <= idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                seed_reg <= seed_value;
            end
            if (cmd.draw_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.seed_last = (idx_reg == IDX_LAST);
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign out_valid        = out_valid_reg;
    assign random_word      = word_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_wr |-> (!out_valid_reg || !out_stall))
        else $error("pending output word overwritten");

    a_seed_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seed_wr |-> idx_reg != '0)
        else $error("seed recurrence wrote word zero");

    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(word_reg)))
        else $error("stalled output word changed");

endmodule

// ----- rtl/mersenne_twister_64_top.sv -----
// Top level of the 64-bit Mersenne Twister generator.
// After reset, and after every write of the seed, the block fills its 312-word state memory
// from the seed with the multiplier recurrence: it writes the first word straight from the seed and
// each of the other 311 in turn with one 32-by-32 multiplier used three times per word, and no
// word is accepted on the input channel until the pass ends. A word with advance set then reads
// the three state words it needs through the two read ports of the state memory, a pair and then
// the middle word, twists and writes back the state word and loads the tempered result, waiting
// while a previous result is still held on the output, and returns to idle. A word with advance
// clear gives no result. A new request is accepted while the previous result still waits on the
// output.
module mersenne_twister_64_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] seed_value,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        advance,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_word
);
    import mt64_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    mt64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .advance   (advance),
        .cfg_write (cfg_write),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    mt64_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .seed_value  (seed_value),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .random_word (random_word)
    );

endmodule
